/* design/dct_pkg.sv */
// Package for the character tokenizer: sizes, codes, record type and character functions.
package dct_pkg;

	// Width of position and length counters
	localparam int POS_BITS = 16;

	// Result queue sizing; one character makes at most three records
	localparam int Q_DEPTH     = 8;
	localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);
	localparam int MAX_BURST   = 3;
	localparam int NKEYS       = 9;

	// Token kinds
	localparam logic [4:0] KIND_UNKNOWN   = 5'd0;
	localparam logic [4:0] KIND_ADD_FIELD = 5'd1;
	localparam logic [4:0] KIND_NUMBER    = 5'd10;
	localparam logic [4:0] KIND_IDENT     = 5'd11;
	localparam logic [4:0] KIND_STRING    = 5'd12;
	localparam logic [4:0] KIND_SEMI      = 5'd13;
	localparam logic [4:0] KIND_PLUS      = 5'd14;
	localparam logic [4:0] KIND_MINUS     = 5'd15;
	localparam logic [4:0] KIND_COMMA     = 5'd16;
	localparam logic [4:0] KIND_LPAREN    = 5'd17;
	localparam logic [4:0] KIND_RPAREN    = 5'd18;
	localparam logic [4:0] KIND_LBRACE    = 5'd19;
	localparam logic [4:0] KIND_RBRACE    = 5'd20;
	localparam logic [4:0] KIND_END       = 5'd21;

	// Characters with a role of their own
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_STR  = 2'd2,
		MODE_CMT  = 2'd3
	} scan_mode_t;

	typedef enum logic [4:0] {
		NS_START, NS_DEC, NS_ZERO, NS_E, NS_EDIG, NS_X, NS_HEX, NS_P, NS_PDIG,
		NS_I1, NS_I2, NS_INF, NS_I4, NS_I5, NS_I6, NS_I7, NS_INFTY,
		NS_N1, NS_N2, NS_NAN, NS_DEAD
	} num_state_t;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] start_offset;
		logic [15:0] text_length;
		logic [7:0]  odd_char;
		logic        burst_end;
	} tok_rec_t;

	// Character classes
	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// Saturating increment of a position counter
	function automatic pos_t sat_inc(pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	// Clamp a position to the 16-bit output field
	function automatic logic [15:0] out_sat(pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	// Keyword lengths
	function automatic logic [3:0] key_len(int k);
		case (k)
			0: return 4'd8;
			1: return 4'd9;
			2: return 4'd13;
			3: return 4'd15;
			4: return 4'd15;
			5: return 4'd11;
			6: return 4'd6;
			7: return 4'd6;
			8: return 4'd4;
			default: return 4'd0;
		endcase
	endfunction

	// Byte i of keyword k; i must be below the keyword length
	function automatic logic [7:0] key_byte(int k, logic [3:0] i);
		logic [127:0] s;
		int sh;
		case (k)
			0: s = "addField";
			1: s = "addObject";
			2: s = "setObjectProp";
			3: s = "initialPosition";
			4: s = "initialVelocity";
			5: s = "setVariable";
			6: s = "string";
			7: s = "number";
			8: s = "loop";
			default: s = '0;
		endcase
		sh = 8 * (int'(key_len(k)) - 1 - int'(i));
		if (sh < 0) begin
			return 8'h00;
		end
		return s[sh +: 8];
	endfunction

	// Drop keywords that no longer match at this character position
	function automatic logic [NKEYS-1:0] keys_next(logic [NKEYS-1:0] alive, pos_t idx,
		logic [7:0] c);
		logic [NKEYS-1:0] a;
		a = alive;
		for (int k = 0; k < NKEYS; k++) begin
			if (32'(idx) >= 32'(key_len(k))) begin
				a[k] = 1'b0;
			end else if (key_byte(k, idx[3:0]) != c) begin
				a[k] = 1'b0;
			end
		end
		return a;
	endfunction

	// Number literal recognizer, one character a step
	function automatic num_state_t num_next(num_state_t s, logic [7:0] c);
		logic [7:0] l;
		l = lower(c);
		case (s)
			NS_START: begin
				if (c == "0") return NS_ZERO;
				if (is_digit(c)) return NS_DEC;
				if (l == "i") return NS_I1;
				if (l == "n") return NS_N1;
				return NS_DEAD;
			end
			NS_ZERO: begin
				if (l == "x") return NS_X;
				if (is_digit(c)) return NS_DEC;
				if (l == "e") return NS_E;
				return NS_DEAD;
			end
			NS_DEC: begin
				if (is_digit(c)) return NS_DEC;
				if (l == "e") return NS_E;
				return NS_DEAD;
			end
			NS_E, NS_EDIG: return is_digit(c) ? NS_EDIG : NS_DEAD;
			NS_X: return is_hex(c) ? NS_HEX : NS_DEAD;
			NS_HEX: begin
				if (is_hex(c)) return NS_HEX;
				return (l == "p") ? NS_P : NS_DEAD;
			end
			NS_P, NS_PDIG: return is_digit(c) ? NS_PDIG : NS_DEAD;
			NS_I1: return (l == "n") ? NS_I2 : NS_DEAD;
			NS_I2: return (l == "f") ? NS_INF : NS_DEAD;
			NS_INF: return (l == "i") ? NS_I4 : NS_DEAD;
			NS_I4: return (l == "n") ? NS_I5 : NS_DEAD;
			NS_I5: return (l == "i") ? NS_I6 : NS_DEAD;
			NS_I6: return (l == "t") ? NS_I7 : NS_DEAD;
			NS_I7: return (l == "y") ? NS_INFTY : NS_DEAD;
			NS_N1: return (l == "a") ? NS_N2 : NS_DEAD;
			NS_N2: return (l == "n") ? NS_NAN : NS_DEAD;
			default: return NS_DEAD;
		endcase
	endfunction

	function automatic logic num_accept(num_state_t s);
		return s == NS_DEC || s == NS_ZERO || s == NS_EDIG || s == NS_HEX ||
			s == NS_PDIG || s == NS_INF || s == NS_INFTY || s == NS_NAN;
	endfunction

	// Kind of a finished word: keyword, number or identifier
	function automatic logic [4:0] word_kind(logic [NKEYS-1:0] alive, pos_t len,
		num_state_t ns);
		logic [4:0] kind;
		kind = KIND_IDENT;
		if (len != '1) begin
			for (int k = NKEYS - 1; k >= 0; k--) begin
				if (alive[k] && 32'(len) == 32'(key_len(k))) begin
					kind = KIND_ADD_FIELD + 5'(k);
				end
			end
			if (kind == KIND_IDENT && num_accept(ns)) begin
				kind = KIND_NUMBER;
			end
		end
		return kind;
	endfunction

endpackage

/* design/dct_char_if.sv */
// Channel interfaces: source characters in, token records out.
interface dct_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       final_char;

	modport source (output valid, output ch, output final_char, input ready);
	modport sink (input valid, input ch, input final_char, output ready);
endinterface

interface dct_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] text_length;
	logic [7:0]  odd_char;
	logic        burst_end;

	modport source (output valid, output token_kind, output start_offset,
		output text_length, output odd_char, output burst_end, input ready);
	modport sink (input valid, input token_kind, input start_offset,
		input text_length, input odd_char, input burst_end, output ready);
endinterface

/* design/dsl_char_tokenizer.sv */
// A character is first registered in the input stage; its token records are then written to the result queue.
// Further records of the same character follow one per cycle from an 8-entry result queue while the output takes them.
// Throughput: one character per cycle while the queue has room for a full burst of three;
// sustained rate is set by the output side taking one record per cycle.
// Reset (arst_n low, asynchronous): scanner back to idle at offset 0, queue and input stage empty.
module dsl_char_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	dct_char_if.sink    char_in,
	dct_tok_if.source   token_out
);

	// Input stage
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       fin_s1;

	// Scanner state
	dct_pkg::scan_mode_t          mode_q;
	dct_pkg::pos_t                pos_q;
	dct_pkg::pos_t                tstart_q;
	dct_pkg::pos_t                wlen_q;
	logic [dct_pkg::NKEYS-1:0]    alive_q;
	dct_pkg::num_state_t          ns_q;

	// Next state and records of the character in the input stage
	dct_pkg::scan_mode_t          mode_n;
	dct_pkg::pos_t                pos_n;
	dct_pkg::pos_t                tstart_n;
	dct_pkg::pos_t                wlen_n;
	logic [dct_pkg::NKEYS-1:0]    alive_n;
	dct_pkg::num_state_t          ns_n;
	dct_pkg::tok_rec_t            rec_c [dct_pkg::MAX_BURST];
	logic [1:0]                   nrec_c;

	// Result queue
	dct_pkg::tok_rec_t                 fifo_q [dct_pkg::Q_DEPTH];
	logic [dct_pkg::Q_PTR_BITS-1:0]    wr_ptr_q;
	logic [dct_pkg::Q_PTR_BITS-1:0]    rd_ptr_q;
	logic [dct_pkg::Q_CNT_BITS-1:0]    count_q;

	logic push;
	logic pop;
	logic room;

	assign room = count_q <= dct_pkg::Q_CNT_BITS'(dct_pkg::Q_DEPTH - dct_pkg::MAX_BURST);
	assign push = v_s1 && room;
	assign pop  = token_out.valid && token_out.ready;
	assign char_in.ready = !v_s1 || push;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_in.ready) begin
			v_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			ch_s1  <= char_in.ch;
			fin_s1 <= char_in.final_char;
		end
	end

	// Scanner: records and next state for one character
	always_comb begin
		logic       fresh;
		logic       alnum;
		logic [1:0] n;
		fresh    = 1'b0;
		alnum    = ch_s1 < 8'd128 && (dct_pkg::is_alpha(ch_s1) || dct_pkg::is_digit(ch_s1));
		n        = 2'd0;
		mode_n   = mode_q;
		tstart_n = tstart_q;
		wlen_n   = wlen_q;
		alive_n  = alive_q;
		ns_n     = ns_q;
		for (int i = 0; i < dct_pkg::MAX_BURST; i++) begin
			rec_c[i] = '0;
		end

		case (mode_q)
			dct_pkg::MODE_WORD: begin
				if (alnum) begin
					alive_n = dct_pkg::keys_next(alive_q, wlen_q, ch_s1);
					ns_n    = dct_pkg::num_next(ns_q, ch_s1);
					wlen_n  = dct_pkg::sat_inc(wlen_q);
				end else begin
					rec_c[n].token_kind   = dct_pkg::word_kind(alive_q, wlen_q, ns_q);
					rec_c[n].start_offset = dct_pkg::out_sat(tstart_q);
					rec_c[n].text_length  = dct_pkg::out_sat(wlen_q);
					n      = n + 2'd1;
					mode_n = dct_pkg::MODE_IDLE;
					fresh  = 1'b1;
				end
			end
			dct_pkg::MODE_STR: begin
				if (ch_s1 == dct_pkg::CH_QUOTE) begin
					rec_c[n].token_kind   = dct_pkg::KIND_STRING;
					rec_c[n].start_offset = dct_pkg::out_sat(tstart_q);
					rec_c[n].text_length  = dct_pkg::out_sat(wlen_q);
					n      = n + 2'd1;
					mode_n = dct_pkg::MODE_IDLE;
				end else begin
					wlen_n = dct_pkg::sat_inc(wlen_q);
				end
			end
			dct_pkg::MODE_CMT: begin
				if (ch_s1 == dct_pkg::CH_NEWLINE) begin
					mode_n = dct_pkg::MODE_IDLE;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		// Character outside any token
		if (fresh) begin
			if (dct_pkg::is_space(ch_s1)) begin
				mode_n = dct_pkg::MODE_IDLE;
			end else if (ch_s1 == dct_pkg::CH_HASH) begin
				mode_n = dct_pkg::MODE_CMT;
			end else if (ch_s1 == dct_pkg::CH_QUOTE) begin
				mode_n   = dct_pkg::MODE_STR;
				tstart_n = dct_pkg::sat_inc(pos_q);
				wlen_n   = '0;
			end else if (alnum) begin
				mode_n   = dct_pkg::MODE_WORD;
				tstart_n = pos_q;
				alive_n  = dct_pkg::keys_next('1, '0, ch_s1);
				ns_n     = dct_pkg::num_next(dct_pkg::NS_START, ch_s1);
				wlen_n   = dct_pkg::pos_t'(1);
			end else begin
				rec_c[n].start_offset = dct_pkg::out_sat(pos_q);
				rec_c[n].text_length  = 16'd1;
				rec_c[n].odd_char     = 8'h00;
				case (ch_s1)
					";": rec_c[n].token_kind = dct_pkg::KIND_SEMI;
					"+": rec_c[n].token_kind = dct_pkg::KIND_PLUS;
					"-": rec_c[n].token_kind = dct_pkg::KIND_MINUS;
					",": rec_c[n].token_kind = dct_pkg::KIND_COMMA;
					"(": rec_c[n].token_kind = dct_pkg::KIND_LPAREN;
					")": rec_c[n].token_kind = dct_pkg::KIND_RPAREN;
					"{": rec_c[n].token_kind = dct_pkg::KIND_LBRACE;
					"}": rec_c[n].token_kind = dct_pkg::KIND_RBRACE;
					default: begin
						rec_c[n].token_kind = dct_pkg::KIND_UNKNOWN;
						rec_c[n].odd_char   = ch_s1;
					end
				endcase
				n = n + 2'd1;
			end
		end

		pos_n = dct_pkg::sat_inc(pos_q);

		// End of source: close open token, add end token, restart
		if (fin_s1) begin
			if (mode_n == dct_pkg::MODE_WORD) begin
				rec_c[n].token_kind   = dct_pkg::word_kind(alive_n, wlen_n, ns_n);
				rec_c[n].start_offset = dct_pkg::out_sat(tstart_n);
				rec_c[n].text_length  = dct_pkg::out_sat(wlen_n);
				n = n + 2'd1;
			end else if (mode_n == dct_pkg::MODE_STR) begin
				rec_c[n].token_kind   = dct_pkg::KIND_STRING;
				rec_c[n].start_offset = dct_pkg::out_sat(tstart_n);
				rec_c[n].text_length  = dct_pkg::out_sat(wlen_n);
				n = n + 2'd1;
			end
			rec_c[n].token_kind   = dct_pkg::KIND_END;
			rec_c[n].start_offset = dct_pkg::out_sat(pos_n);
			n = n + 2'd1;
			mode_n   = dct_pkg::MODE_IDLE;
			pos_n    = '0;
			tstart_n = '0;
			wlen_n   = '0;
			alive_n  = '1;
			ns_n     = dct_pkg::NS_START;
		end

		// Mark the last record of the burst
		for (int i = 0; i < dct_pkg::MAX_BURST; i++) begin
			rec_c[i].burst_end = (n == 2'(i + 1));
		end
		nrec_c = n;
	end

	// Scanner state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= dct_pkg::MODE_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
			wlen_q   <= '0;
			alive_q  <= '1;
			ns_q     <= dct_pkg::NS_START;
		end else if (push) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			tstart_q <= tstart_n;
			wlen_q   <= wlen_n;
			alive_q  <= alive_n;
			ns_q     <= ns_n;
		end
	end

	// Queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dct_pkg::Q_PTR_BITS'(nrec_c);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dct_pkg::Q_PTR_BITS'(1);
			end
			count_q <= count_q + (push ? dct_pkg::Q_CNT_BITS'(nrec_c) : '0)
				- (pop ? dct_pkg::Q_CNT_BITS'(1) : '0);
		end
	end

	// Queue storage: up to three records written per transaction
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < dct_pkg::MAX_BURST; i++) begin
				if (2'(i) < nrec_c) begin
					fifo_q[wr_ptr_q + dct_pkg::Q_PTR_BITS'(i)] <= rec_c[i];
				end
			end
		end
	end

	// Output side
	assign token_out.valid        = count_q != '0;
	assign token_out.token_kind   = fifo_q[rd_ptr_q].token_kind;
	assign token_out.start_offset = fifo_q[rd_ptr_q].start_offset;
	assign token_out.text_length  = fifo_q[rd_ptr_q].text_length;
	assign token_out.odd_char     = fifo_q[rd_ptr_q].odd_char;
	assign token_out.burst_end    = fifo_q[rd_ptr_q].burst_end;

`ifndef SYNTHESIS
	// Queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dct_pkg::Q_CNT_BITS'(dct_pkg::Q_DEPTH))
		else $error("result queue overflow");

	// A final character always yields at least its end token
	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(push && fin_s1) |-> nrec_c != 2'd0)
		else $error("final character produced no record");

	// After the final character the scanner restarts at offset zero
	a_final_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(push && fin_s1) |=> (mode_q == dct_pkg::MODE_IDLE && pos_q == '0))
		else $error("scanner not restarted after final character");

	// The end token closes its burst
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_out.valid && token_out.token_kind == dct_pkg::KIND_END) |-> token_out.burst_end)
		else $error("end token not last of burst");
`endif

endmodule
